[hw/rtl/oia_pkg.sv]
// Shared constants, codes and helper functions of the object id allocator.
package oia_pkg;

  // Sizing
  localparam int SWITCH_SLOTS = 256;
  localparam int TYPE_COUNT   = 128;
  localparam int SERIAL_BITS  = 32;

  // Field positions inside a 64-bit object id
  localparam int TYPE_POS  = 32;
  localparam int INDEX_POS = 40;

  localparam int CMD_W    = 3;
  localparam int TYPE_W   = 8;
  localparam int ID_W     = 64;
  localparam int STATUS_W = 3;

  localparam logic [31:0] SERIAL_MASK = 32'((64'd1 << SERIAL_BITS) - 64'd1);

  // Derived sizes
  localparam int SLOT_AW     = (SWITCH_SLOTS > 1) ? $clog2(SWITCH_SLOTS) : 1;
  localparam int TYPE_AW     = $clog2(TYPE_COUNT);
  localparam int CHUNK_W     = (SWITCH_SLOTS < 64) ? SWITCH_SLOTS : 64;
  localparam int SLOT_CHUNKS = (SWITCH_SLOTS + CHUNK_W - 1) / CHUNK_W;
  localparam int POS_W       = (CHUNK_W > 1) ? $clog2(CHUNK_W) : 1;
  localparam int CHUNK_AW    = (SLOT_CHUNKS > 1) ? $clog2(SLOT_CHUNKS) : 1;

  localparam logic [TYPE_W-1:0] SWITCH_CODE_RST = 8'd33;

  // Commands
  localparam logic [CMD_W-1:0] CMD_CREATE     = 3'd0;
  localparam logic [CMD_W-1:0] CMD_FREE       = 3'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY      = 3'd2;
  localparam logic [CMD_W-1:0] CMD_CLR_COUNTS = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLR_SLOTS  = 3'd4;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_TYPE   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NO_SLOT    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_SWITCH = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EXHAUSTED  = 3'd4;

  // Type carried by an id; 0 for the null id or an out-of-range type
  function automatic logic [TYPE_W-1:0] decode_type(input logic [ID_W-1:0] id);
    logic [TYPE_W-1:0] t;
    t = id[TYPE_POS +: TYPE_W];
    if (id == '0 || t == '0 || {1'b0, t} >= 9'(TYPE_COUNT)) begin
      return '0;
    end
    return t;
  endfunction

  function automatic logic [ID_W-1:0] pack_id(input logic [7:0]        idx,
                                               input logic [TYPE_W-1:0] typ,
                                               input logic [31:0]       serial);
    return {16'h0000, idx, typ, serial & SERIAL_MASK};
  endfunction

endpackage

[hw/rtl/oia_if.sv]
// Valid/ready channel interfaces of the object id allocator.
interface oia_in_if import oia_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [TYPE_W-1:0] obj_type;
  logic [ID_W-1:0]   id_in;

  modport source (output valid, output cmd, output obj_type, output id_in,
                  input ready);
  modport sink   (input valid, input cmd, input obj_type, input id_in,
                  output ready);
endinterface

interface oia_out_if import oia_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ID_W-1:0]     id_out;
  logic [TYPE_W-1:0]   type_out;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output id_out, output type_out, output status,
                  input ready);
  modport sink   (input valid, input id_out, input type_out, input status,
                  output ready);
endinterface

interface oia_cfg_if import oia_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [TYPE_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[hw/rtl/object_id_allocator.sv]
// Object id allocator: switch slot map, per-type serial counters and command sequencer.
//
// One command word is taken at a time; in_chan.ready is high only while the
// sequencer is idle. Clear, free, query and unused commands and creates
// rejected at decode pass from acceptance to the next acceptance through
// decode, result hand-off and idle. A create of a non-switch type adds the
// counter step for the registered read of the serial counter memory. A create
// of the switch type scans the slot map for the lowest free slot with one
// 64-bit find-first-zero per cycle, visiting between 1 and 4 chunks of 64
// slots. The result sits in an output register until taken; the
// sequencer stalls in its hand-off step only if an earlier result is still
// waiting. The slot map is a flip-flop vector and the counters keep one valid
// bit each, so reset and both clear commands take effect at once with no
// clearing pass. The switch type code register (reset 33) is written through
// cfg_chan, which is always ready; write it only while the block is idle.
module object_id_allocator import oia_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  oia_cfg_if.sink   cfg_chan,
  oia_in_if.sink    in_chan,
  oia_out_if.source out_chan
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_SEARCH = 3'd2;
  localparam logic [2:0] S_COUNT  = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  localparam logic [CHUNK_AW-1:0] LAST_CHUNK = CHUNK_AW'(SLOT_CHUNKS - 1);

  logic [2:0]              state_r;
  logic [TYPE_W-1:0]       switch_code_r;

  // accepted command word
  logic [CMD_W-1:0]        cmd_r;
  logic [TYPE_W-1:0]       otype_r;
  logic [ID_W-1:0]         id_r;

  // result awaiting hand-off
  logic [ID_W-1:0]         res_id_r;
  logic [TYPE_W-1:0]       res_type_r;
  logic [STATUS_W-1:0]     res_status_r;

  // output register
  logic                    out_valid_r;
  logic [ID_W-1:0]         out_id_r;
  logic [TYPE_W-1:0]       out_type_r;
  logic [STATUS_W-1:0]     out_status_r;

  // slot map and search
  logic [SWITCH_SLOTS-1:0]         slot_used_r;
  logic [SLOT_CHUNKS*CHUNK_W-1:0]  slot_map_pad;
  logic [CHUNK_AW-1:0]             chunk_r;
  logic [CHUNK_W-1:0]              srch_word;
  logic                            srch_hit;
  logic [POS_W-1:0]                srch_pos;
  logic [7:0]                      srch_slot;

  // serial counters
  logic [SERIAL_BITS-1:0]  cnt_mem [TYPE_COUNT];
  logic [TYPE_COUNT-1:0]   cnt_vld_r;
  logic [SERIAL_BITS-1:0]  cnt_rd_r;
  logic [TYPE_AW-1:0]      cnt_addr;
  logic [SERIAL_BITS-1:0]  cnt_cur;
  logic                    cnt_exh;
  logic                    cnt_we;

  // decode of the held command word
  logic [TYPE_W-1:0]       id_type;
  logic [7:0]              id_idx;
  logic                    id_is_switch;
  logic                    otype_bad;
  logic                    idx_in_range;
  logic                    handoff;

  assign in_chan.ready  = (state_r == S_IDLE);
  assign cfg_chan.ready = 1'b1;

  assign out_chan.valid    = out_valid_r;
  assign out_chan.id_out   = out_id_r;
  assign out_chan.type_out = out_type_r;
  assign out_chan.status   = out_status_r;

  assign id_type      = decode_type(id_r);
  assign id_idx       = id_r[INDEX_POS +: 8];
  assign id_is_switch = (id_type != '0) && (id_type == switch_code_r);
  assign otype_bad    = (otype_r == '0) || ({1'b0, otype_r} >= 9'(TYPE_COUNT));
  assign idx_in_range = ({1'b0, id_idx} < 9'(SWITCH_SLOTS));
  assign handoff      = (state_r == S_DONE) && (!out_valid_r || out_chan.ready);

  // Slot search: lowest free slot of the current chunk; slots past the end read as used
  always_comb begin
    slot_map_pad = '1;
    slot_map_pad[SWITCH_SLOTS-1:0] = slot_used_r;
    srch_word = slot_map_pad[int'(chunk_r) * CHUNK_W +: CHUNK_W];
    srch_hit  = ~&srch_word;
    srch_pos  = '0;
    for (int i = CHUNK_W - 1; i >= 0; i--) begin
      if (!srch_word[i]) begin
        srch_pos = POS_W'(i);
      end
    end
    srch_slot = 8'(int'(chunk_r) * CHUNK_W + int'(srch_pos));
  end

  // Counter memory: read every cycle at the held type, result used in S_COUNT
  assign cnt_addr = otype_r[TYPE_AW-1:0];
  assign cnt_cur  = cnt_vld_r[cnt_addr] ? cnt_rd_r : '0;
  assign cnt_exh  = (cnt_cur == {SERIAL_BITS{1'b1}});
  assign cnt_we   = (state_r == S_COUNT) && !cnt_exh;

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_addr] <= cnt_cur + SERIAL_BITS'(1);
    end
    cnt_rd_r <= cnt_mem[cnt_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_vld_r <= '0;
    end else if (state_r == S_DECODE && cmd_r == CMD_CLR_COUNTS) begin
      cnt_vld_r <= '0;
    end else if (cnt_we) begin
      cnt_vld_r[cnt_addr] <= 1'b1;
    end
  end

  // Slot map
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_used_r <= '0;
    end else if (state_r == S_DECODE && cmd_r == CMD_CLR_SLOTS) begin
      slot_used_r <= '0;
    end else if (state_r == S_DECODE && cmd_r == CMD_FREE && id_is_switch &&
                 idx_in_range) begin
      slot_used_r[id_idx[SLOT_AW-1:0]] <= 1'b0;
    end else if (state_r == S_SEARCH && srch_hit) begin
      slot_used_r[srch_slot[SLOT_AW-1:0]] <= 1'b1;
    end
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      switch_code_r <= SWITCH_CODE_RST;
    end else if (cfg_chan.valid) begin
      switch_code_r <= cfg_chan.data;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      chunk_r <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_chan.valid) begin
            cmd_r   <= in_chan.cmd;
            otype_r <= in_chan.obj_type;
            id_r    <= in_chan.id_in;
            state_r <= S_DECODE;
          end
        end
        S_DECODE: begin
          res_id_r     <= '0;
          res_type_r   <= '0;
          res_status_r <= ST_OK;
          chunk_r      <= '0;
          state_r      <= S_DONE;
          unique case (cmd_r)
            CMD_CREATE: begin
              priority if (otype_bad) begin
                res_status_r <= ST_BAD_TYPE;
              end else if (otype_r == switch_code_r) begin
                state_r <= S_SEARCH;
              end else if (!id_is_switch) begin
                res_status_r <= ST_NOT_SWITCH;
              end else begin
                state_r <= S_COUNT;
              end
            end
            CMD_FREE: begin
              if (id_is_switch && !idx_in_range) begin
                res_status_r <= ST_NOT_SWITCH;
              end
            end
            CMD_QUERY: begin
              if (id_r != '0) begin
                res_type_r <= id_type;
                priority if (id_type == '0) begin
                  res_status_r <= ST_BAD_TYPE;
                end else if (id_type == switch_code_r) begin
                  res_id_r <= id_r;
                end else begin
                  res_id_r <= pack_id(id_idx, switch_code_r, 32'(id_idx));
                end
              end
            end
            default: begin
              // clears act on the maps directly; unused codes do nothing
            end
          endcase
        end
        S_SEARCH: begin
          priority if (srch_hit) begin
            res_id_r <= pack_id(srch_slot, otype_r, 32'(srch_slot));
            state_r  <= S_DONE;
          end else if (chunk_r == LAST_CHUNK) begin
            res_status_r <= ST_NO_SLOT;
            state_r      <= S_DONE;
          end else begin
            chunk_r <= chunk_r + 1'b1;
          end
        end
        S_COUNT: begin
          if (cnt_exh) begin
            res_status_r <= ST_EXHAUSTED;
          end else begin
            res_id_r <= pack_id(id_idx, otype_r, 32'(cnt_cur));
          end
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (handoff) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (handoff) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (handoff) begin
      out_id_r     <= res_id_r;
      out_type_r   <= res_type_r;
      out_status_r <= res_status_r;
    end
  end

  // Checks
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.valid && in_chan.ready |=> !in_chan.ready)
    else $error("command word accepted while another is in progress");

  a_slot_taken: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SEARCH && srch_hit |=> slot_used_r[$past(srch_slot[SLOT_AW-1:0])])
    else $error("allocated switch slot not marked as used");

  a_full_means_full: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SEARCH && !srch_hit && chunk_r == LAST_CHUNK |-> &slot_used_r)
    else $error("slot map reported full with a free slot left");

  a_chunk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SEARCH |-> chunk_r <= LAST_CHUNK)
    else $error("slot search ran past the last chunk");

endmodule
